// ===== rtl/hill_cipher_3x3_stream_unit_assert.svh =====
// assertion macros used by the port-level checker
`ifndef HILL_CIPHER_3X3_STREAM_UNIT_ASSERT_SVH
`define HILL_CIPHER_3X3_STREAM_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HC3_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hc3 assertion failed");

// next-cycle implication, disabled while reset is low
`define HC3_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hc3 assertion failed");

`endif

// ===== rtl/hc3_pkg.sv =====
// types, constants and helpers of the 3x3 hill cipher stream unit
package hc3_pkg;

  localparam int unsigned KEY_W = 45;
  localparam int unsigned SYM_W = 5;
  localparam int unsigned ACC_W = 12;

  localparam logic [KEY_W-1:0] KEY_RESET = 45'd6598315478081;

  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;

  localparam logic [SYM_W-1:0] PAD_SYM  = 5'd23;
  localparam logic [SYM_W-1:0] WIDE_SYM = 5'd13;

  localparam logic [6:0] LETTER_BASE = 7'd65;
  localparam logic [7:0] MOD_BASE    = 8'd26;
  // floor(x/26) == (x * MOD_RECIP) >> 16 for every x below 4096
  localparam logic [ACC_W-1:0] MOD_RECIP = 12'd2521;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [6:0] cipher_letter;
    logic       last_of_group;
    logic       end_of_message;
  } out_t;

  // one triplet of symbols, sym[0] is the first symbol
  typedef struct packed {
    logic [2:0][SYM_W-1:0] sym;
    logic                  eom;
  } trip_t;

  typedef struct packed {
    logic  valid;
    trip_t trip;
  } trip_xfer_t;

  function automatic logic [SYM_W-1:0] mod26(input logic [ACC_W-1:0] x);
    logic [2*ACC_W-1:0] prod;
    logic [7:0]         quo;
    logic [ACC_W-1:0]   rem;
    prod = x * MOD_RECIP;
    quo  = prod[2*ACC_W-1:16];
    rem  = x - ACC_W'(quo * MOD_BASE);
    return rem[SYM_W-1:0];
  endfunction

endpackage

// ===== rtl/hill_cipher_3x3_stream_unit.sv =====
// a byte that closes a triplet goes through the queue, the s1 register and the output
// register before its first letter shows; the other two follow as the sink takes them
// throughput: one byte per cycle while the queue has room; the back end emits one letter
// per cycle when not stalled; a message end on every byte is bound by the back end
// reset: asynchronous, clears the symbol count, queue and pipeline, key to its reset value
module hill_cipher_3x3_stream_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hc3_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hc3_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import hc3_pkg::*;

  logic [KEY_W-1:0] key_q;
  trip_xfer_t       push;
  logic             push_ready;
  trip_xfer_t       head;
  logic             pop;

  assign pready = 1'b1;
  // one 64-bit register, index taken from paddr[3]
  assign prdata = paddr[3] ? '0 : {{(64 - KEY_W){1'b0}}, key_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      key_q <= pwdata[KEY_W-1:0];
    end
  end

  hc3_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  hc3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  hc3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/hc3_front.sv =====
// front end: maps bytes to symbols, gathers triplets and pads on the last byte
module hc3_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hc3_pkg::in_t        in_data_i,
  output hc3_pkg::trip_xfer_t push_o,
  input  logic                push_ready_i
);
  import hc3_pkg::*;

  logic                 prev_high_q, prev_high_d;
  logic [1:0]           count_q, count_d;
  logic [SYM_W-1:0]     held_q [2];
  logic [SYM_W-1:0]     held_d [2];
  logic                 accept;
  logic                 have;
  logic [SYM_W-1:0]     sym;
  logic [7:0]           b;
  logic                 complete;
  logic [1:0]           count_new;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign b          = in_data_i.text_byte;

  always_comb begin
    have = 1'b0;
    sym  = '0;
    if (b[7]) begin
      have = prev_high_q;
      sym  = WIDE_SYM;
    end else if (b inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}) begin
      have = 1'b1;
      sym  = SYM_W'(b - ASCII_UPPER_A);
    end else if (b inside {[ASCII_LOWER_A:ASCII_LOWER_Z]}) begin
      have = 1'b1;
      sym  = SYM_W'(b - ASCII_LOWER_A);
    end
  end

  always_comb begin
    complete   = have && (count_q == 2'd2);
    held_d[0]  = held_q[0];
    held_d[1]  = held_q[1];
    count_new  = count_q;
    if (complete) begin
      count_new = 2'd0;
    end else if (have) begin
      if (count_q == 2'd0) begin
        held_d[0] = sym;
      end else begin
        held_d[1] = sym;
      end
      count_new = count_q + 2'd1;
    end

    push_o.valid    = 1'b0;
    push_o.trip.sym = {sym, held_q[1], held_q[0]};
    push_o.trip.eom = in_data_i.last_byte;
    if (accept) begin
      if (complete) begin
        push_o.valid = 1'b1;
      end else if (in_data_i.last_byte && (count_new != 2'd0)) begin
        // partial triplet at end of message, pad up to three symbols
        push_o.valid    = 1'b1;
        push_o.trip.sym = {PAD_SYM, (count_new > 2'd1) ? held_d[1] : PAD_SYM, held_d[0]};
      end
    end

    prev_high_d = prev_high_q;
    count_d     = count_q;
    if (accept) begin
      prev_high_d = b[7] & ~in_data_i.last_byte;
      count_d     = in_data_i.last_byte ? 2'd0 : count_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_high_q <= 1'b0;
      count_q     <= 2'd0;
    end else begin
      prev_high_q <= prev_high_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q[0] <= held_d[0];
      held_q[1] <= held_d[1];
    end
  end

endmodule

// ===== rtl/hc3_queue.sv =====
// short triplet queue between front and back
module hc3_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hc3_pkg::trip_xfer_t push_i,
  output logic                push_ready_o,
  output hc3_pkg::trip_xfer_t head_o,
  input  logic                pop_i
);
  import hc3_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  trip_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign do_push      = push_i.valid & push_ready_o;
  assign do_pop       = pop_i & (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.trip  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.trip;
    end
  end

endmodule

// ===== rtl/hc3_back.sv =====
// back end: one key row per cycle while the output is not stalled, reduce modulo 26, emit letters
module hc3_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [hc3_pkg::KEY_W-1:0] key_i,
  input  hc3_pkg::trip_xfer_t      head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output hc3_pkg::out_t            out_data_o
);
  import hc3_pkg::*;

  logic [1:0]        row_q, row_d;
  logic              s1_valid_q;
  logic [ACC_W-1:0]  acc_q;
  logic              s1_log_q, s1_eom_q;
  logic              out_valid_q;
  out_t              out_data_q;
  logic              s1_en, s2_en, take;
  logic [14:0]       krow;
  logic [ACC_W-1:0]  acc_d;
  logic [9:0]        prod [3];

  assign s2_en = !out_valid_q || out_ready_i;
  assign s1_en = !s1_valid_q || s2_en;
  assign take  = head_i.valid && s1_en;
  assign pop_o = take && (row_q == 2'd2);

  always_comb begin
    case (row_q)
      2'd0:    krow = key_i[14:0];
      2'd1:    krow = key_i[29:15];
      2'd2:    krow = key_i[44:30];
      default: krow = '0;
    endcase
    for (int c = 0; c < 3; c++) begin
      prod[c] = krow[5*c +: 5] * head_i.trip.sym[c];
    end
    acc_d = ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]);
    row_d = row_q;
    if (take) begin
      row_d = (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= 2'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      row_q <= row_d;
      if (s1_en) begin
        s1_valid_q <= take;
      end
      if (s2_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q    <= acc_d;
      s1_log_q <= (row_q == 2'd2);
      s1_eom_q <= head_i.trip.eom;
    end
    if (s2_en && s1_valid_q) begin
      out_data_q.cipher_letter  <= LETTER_BASE + 7'(mod26(acc_q));
      out_data_q.last_of_group  <= s1_log_q;
      out_data_q.end_of_message <= s1_eom_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/hc3_checker.sv =====
// port-level checker for the hill cipher stream unit, bound to the top level
`include "hill_cipher_3x3_stream_unit_assert.svh"

module hc3_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input hc3_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input hc3_pkg::out_t out_data_o,
  input logic          psel,
  input logic          penable,
  input logic          pwrite,
  input logic [3:0]    paddr,
  input logic [63:0]   pwdata,
  input logic [63:0]   prdata,
  input logic          pready
);
  import hc3_pkg::*;

  // letters always land in A..Z
  `HC3_ASSERT_IMPL(a_letter_range, clk_i, rst_ni, out_valid_o,
    (out_data_o.cipher_letter >= 7'd65) && (out_data_o.cipher_letter <= 7'd90))

  // a stalled result holds
  `HC3_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o))

  // a waiting input byte holds
  `HC3_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o,
    in_valid_i && $stable(in_data_i))

  // a key write reads back on the next cycle
  `HC3_ASSERT_NEXT(a_key_readback, clk_i, rst_ni,
    psel && penable && pwrite && pready && !paddr[3],
    paddr[3] || (prdata == {19'd0, $past(pwdata[44:0])}))

endmodule

bind hill_cipher_3x3_stream_unit hc3_checker u_hc3_checker (.*);
